// ----- src/fpp_pkg.sv -----
// Shared types and codes for the FEN position parser.
// No dependencies; used by fpp_parser, fpp_outq and fen_position_parser.
`timescale 1ns / 1ps

package fpp_pkg;

   localparam logic KIND_WRITE   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   localparam logic [3:0] STATUS_OK         = 4'd0;
   localparam logic [3:0] STATUS_FEW_FIELDS = 4'd1;
   localparam logic [3:0] STATUS_PIECE      = 4'd2;
   localparam logic [3:0] STATUS_SIDE       = 4'd3;
   localparam logic [3:0] STATUS_CASTLE     = 4'd4;
   localparam logic [3:0] STATUS_EP         = 4'd5;
   localparam logic [3:0] STATUS_HALF       = 4'd6;
   localparam logic [3:0] STATUS_FULL       = 4'd7;
   localparam logic [3:0] STATUS_FEW_RANKS  = 4'd8;

   localparam int RSP_DATA_W = 64;
   localparam int OUTQ_DEPTH = 4;

   typedef struct packed {
      logic        kind;
      logic [2:0]  rank;
      logic [2:0]  start_file;
      logic [3:0]  run_length;
      logic [3:0]  piece;
      logic        white_to_move;
      logic [3:0]  castle_rights;
      logic [3:0]  ep_column;
      logic [15:0] half_move_clock;
      logic [15:0] full_move_counter;
      logic [3:0]  status;
      logic        last;
   } result_type;

   typedef struct packed {
      logic [1:0] count;
      result_type first;
      result_type second;
   } parse_out_type;

endpackage

// ----- src/fpp_parser.sv -----
// Per-character FEN parse state and result decode.
// Depends on fpp_pkg for the result types and status codes.
`timescale 1ns / 1ps

module fpp_parser (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   accept,
   input  logic [7:0]             char_code,
   input  logic                   end_of_string,
   output fpp_pkg::parse_out_type parse_out
);

   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_DASH  = 8'h2D;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_1     = 8'h31;
   localparam logic [7:0] CH_3     = 8'h33;
   localparam logic [7:0] CH_6     = 8'h36;
   localparam logic [7:0] CH_8     = 8'h38;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_LA    = 8'h61;
   localparam logic [7:0] CH_LH    = 8'h68;
   localparam logic [7:0] CH_W     = 8'h77;
   localparam logic [7:0] CH_B     = 8'h62;
   localparam logic [7:0] CH_UK    = 8'h4B;
   localparam logic [7:0] CH_UQ    = 8'h51;
   localparam logic [7:0] CH_LK    = 8'h6B;
   localparam logic [7:0] CH_LQ    = 8'h71;

   localparam logic [1:0] SIDE_NONE  = 2'd0;
   localparam logic [1:0] SIDE_BLACK = 2'd1;
   localparam logic [1:0] SIDE_OTHER = 2'd2;

   function automatic logic [3:0] piece_code(input logic [7:0] c);
      logic [3:0] code;
      code = 4'd0;
      unique case (c)
         8'h50: code = 4'd1;
         8'h4E: code = 4'd2;
         8'h42: code = 4'd3;
         8'h52: code = 4'd4;
         8'h51: code = 4'd5;
         8'h4B: code = 4'd6;
         8'h70: code = 4'd7;
         8'h6E: code = 4'd8;
         8'h62: code = 4'd9;
         8'h72: code = 4'd10;
         8'h71: code = 4'd11;
         8'h6B: code = 4'd12;
         default: code = 4'd0;
      endcase
      return code;
   endfunction

   function automatic logic [15:0] dec_accum(input logic [15:0] v, input logic [3:0] d);
      logic [20:0] r;
      r = {2'b00, v, 3'b000} + {4'b0000, v, 1'b0} + {17'd0, d};
      return (r > 21'd65535) ? 16'hFFFF : r[15:0];
   endfunction

   logic [2:0]  field_index_ff, field_index_in;
   logic        in_sep_ff, in_sep_in;
   logic [3:0]  rank_count_ff, rank_count_in;
   logic [3:0]  file_pos_ff, file_pos_in;
   logic [5:0]  err_ff, err_in;
   logic [1:0]  side_ff, side_in;
   logic [3:0]  castle_ff, castle_in;
   logic [2:0]  ep_first_ff, ep_first_in;
   logic [1:0]  ep_len_ff, ep_len_in;
   logic [15:0] half_ff, half_in;
   logic [15:0] full_ff, full_in;

   always_comb begin
      logic [2:0]         fi;
      logic [2:0]         f;
      logic [3:0]         pc;
      logic [3:0]         len;
      logic [4:0]         file_sum;
      logic [3:0]         room;
      logic               emit;
      logic [3:0]         emit_len;
      logic [3:0]         emit_piece;
      logic [3:0]         status;
      fpp_pkg::result_type wr;
      fpp_pkg::result_type sm;

      field_index_in = field_index_ff;
      in_sep_in      = in_sep_ff;
      rank_count_in  = rank_count_ff;
      file_pos_in    = file_pos_ff;
      err_in         = err_ff;
      side_in        = side_ff;
      castle_in      = castle_ff;
      ep_first_in    = ep_first_ff;
      ep_len_in      = ep_len_ff;
      half_in        = half_ff;
      full_in        = full_ff;
      emit       = 1'b0;
      emit_len   = 4'd0;
      emit_piece = 4'd0;
      fi         = field_index_ff;
      f          = 3'd0;
      pc         = piece_code(char_code);
      len        = char_code[3:0];
      file_sum   = {1'b0, file_pos_ff} + {1'b0, len};
      room       = 4'd8 - file_pos_ff;

      if (char_code == CH_SPACE) begin
         in_sep_in = 1'b1;
      end else begin
         if (in_sep_ff) begin
            fi = (field_index_ff == 3'd7) ? 3'd7 : field_index_ff + 3'd1;
         end
         field_index_in = fi;
         in_sep_in      = 1'b0;
         f              = fi - 3'd1;
         unique case (f)
            3'd0: begin
               if (char_code == CH_SLASH) begin
                  rank_count_in = (rank_count_ff < 4'd8) ? rank_count_ff + 4'd1 : rank_count_ff;
                  file_pos_in   = 4'd0;
               end else if (char_code >= CH_1 && char_code <= CH_8) begin
                  if (rank_count_ff <= 4'd7 && file_pos_ff < 4'd8) begin
                     emit     = 1'b1;
                     emit_len = (len < room) ? len : room;
                  end
                  file_pos_in = (file_sum > 5'd8) ? 4'd8 : file_sum[3:0];
               end else if (pc == 4'd0) begin
                  err_in[0] = 1'b1;
               end else begin
                  if (rank_count_ff <= 4'd7 && file_pos_ff < 4'd8) begin
                     emit       = 1'b1;
                     emit_len   = 4'd1;
                     emit_piece = pc;
                  end
                  if (file_pos_ff < 4'd8) begin
                     file_pos_in = file_pos_ff + 4'd1;
                  end
               end
            end
            3'd1: begin
               if (char_code != CH_W && char_code != CH_B) begin
                  err_in[1] = 1'b1;
               end
               side_in = (side_ff == SIDE_NONE && char_code == CH_B) ? SIDE_BLACK : SIDE_OTHER;
            end
            3'd2: begin
               if (char_code == CH_UK) begin
                  castle_in[0] = 1'b1;
               end else if (char_code == CH_UQ) begin
                  castle_in[1] = 1'b1;
               end else if (char_code == CH_LK) begin
                  castle_in[2] = 1'b1;
               end else if (char_code == CH_LQ) begin
                  castle_in[3] = 1'b1;
               end else if (char_code != CH_DASH) begin
                  err_in[2] = 1'b1;
               end
            end
            3'd3: begin
               if (!(char_code == CH_DASH || char_code == CH_3 || char_code == CH_6 ||
                     (char_code >= CH_LA && char_code <= CH_LH))) begin
                  err_in[3] = 1'b1;
               end
               if (ep_len_ff == 2'd0) begin
                  ep_first_in = (char_code >= CH_LA && char_code <= CH_LH) ?
                                char_code[2:0] - CH_LA[2:0] : 3'd0;
               end
               if (ep_len_ff < 2'd2) begin
                  ep_len_in = ep_len_ff + 2'd1;
               end
            end
            3'd4: begin
               if (char_code >= CH_0 && char_code <= CH_9) begin
                  half_in = dec_accum(half_ff, len);
               end else begin
                  err_in[4] = 1'b1;
               end
            end
            3'd5: begin
               if (char_code >= CH_0 && char_code <= CH_9) begin
                  full_in = dec_accum(full_ff, len);
               end else begin
                  err_in[5] = 1'b1;
               end
            end
            default: begin
            end
         endcase
      end

      priority if (field_index_in < 3'd4) begin
         status = fpp_pkg::STATUS_FEW_FIELDS;
      end else if (err_in[0]) begin
         status = fpp_pkg::STATUS_PIECE;
      end else if (err_in[1]) begin
         status = fpp_pkg::STATUS_SIDE;
      end else if (err_in[2]) begin
         status = fpp_pkg::STATUS_CASTLE;
      end else if (err_in[3]) begin
         status = fpp_pkg::STATUS_EP;
      end else if (err_in[4]) begin
         status = fpp_pkg::STATUS_HALF;
      end else if (err_in[5]) begin
         status = fpp_pkg::STATUS_FULL;
      end else if (rank_count_in < 4'd7) begin
         status = fpp_pkg::STATUS_FEW_RANKS;
      end else begin
         status = fpp_pkg::STATUS_OK;
      end

      wr            = '0;
      wr.kind       = fpp_pkg::KIND_WRITE;
      wr.rank       = ~rank_count_ff[2:0];
      wr.start_file = file_pos_ff[2:0];
      wr.run_length = emit_len;
      wr.piece      = emit_piece;
      wr.last       = !end_of_string;

      sm        = '0;
      sm.kind   = fpp_pkg::KIND_SUMMARY;
      sm.status = status;
      sm.last   = 1'b1;
      if (status != fpp_pkg::STATUS_OK) begin
         sm.white_to_move = 1'b1;
         sm.castle_rights = 4'hF;
         sm.ep_column     = 4'hF;
      end else begin
         sm.white_to_move     = (side_in != SIDE_BLACK);
         sm.castle_rights     = castle_in;
         sm.ep_column         = (ep_len_in >= 2'd2) ? {1'b0, ep_first_in} : 4'hF;
         sm.half_move_clock   = half_in;
         sm.full_move_counter = full_in;
      end

      parse_out.count  = {1'b0, emit} + {1'b0, end_of_string};
      parse_out.first  = emit ? wr : sm;
      parse_out.second = sm;

      if (end_of_string) begin
         field_index_in = 3'd0;
         in_sep_in      = 1'b1;
         rank_count_in  = 4'd0;
         file_pos_in    = 4'd0;
         err_in         = 6'd0;
         side_in        = SIDE_NONE;
         castle_in      = 4'd0;
         ep_first_in    = 3'd0;
         ep_len_in      = 2'd0;
         half_in        = 16'd0;
         full_in        = 16'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         field_index_ff <= 3'd0;
         in_sep_ff      <= 1'b1;
         rank_count_ff  <= 4'd0;
         file_pos_ff    <= 4'd0;
         err_ff         <= 6'd0;
         side_ff        <= SIDE_NONE;
         castle_ff      <= 4'd0;
         ep_first_ff    <= 3'd0;
         ep_len_ff      <= 2'd0;
         half_ff        <= 16'd0;
         full_ff        <= 16'd0;
      end else if (accept) begin
         field_index_ff <= field_index_in;
         in_sep_ff      <= in_sep_in;
         rank_count_ff  <= rank_count_in;
         file_pos_ff    <= file_pos_in;
         err_ff         <= err_in;
         side_ff        <= side_in;
         castle_ff      <= castle_in;
         ep_first_ff    <= ep_first_in;
         ep_len_ff      <= ep_len_in;
         half_ff        <= half_in;
         full_ff        <= full_in;
      end
   end

endmodule

// ----- src/fpp_outq.sv -----
// Result buffer: a short shift line that takes up to two results per cycle
// and hands out one per cycle while head_ready is high. Depends on fpp_pkg.
`timescale 1ns / 1ps

module fpp_outq (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  fpp_pkg::parse_out_type parse_out,
   output logic                   space_ok,
   output logic                   head_valid,
   input  logic                   head_ready,
   output fpp_pkg::result_type    head
);

   localparam int CNT_W = $clog2(fpp_pkg::OUTQ_DEPTH + 1);
   localparam int IDX_W = $clog2(fpp_pkg::OUTQ_DEPTH);

   fpp_pkg::result_type slot_ff [fpp_pkg::OUTQ_DEPTH];
   fpp_pkg::result_type slot_in [fpp_pkg::OUTQ_DEPTH];
   logic [CNT_W-1:0]    cnt_ff, cnt_in;

   logic             pop;
   logic [CNT_W-1:0] base;
   logic [1:0]       n_push;

   assign pop        = (cnt_ff != '0) && head_ready;
   assign head_valid = (cnt_ff != '0);
   assign head       = slot_ff[0];
   assign space_ok   = (cnt_ff <= CNT_W'(fpp_pkg::OUTQ_DEPTH - 2));
   assign base       = cnt_ff - CNT_W'(pop);
   assign n_push     = push ? parse_out.count : 2'd0;
   assign cnt_in     = base + CNT_W'(n_push);

   always_comb begin
      for (int i = 0; i < fpp_pkg::OUTQ_DEPTH; i++) begin
         if (pop && i < fpp_pkg::OUTQ_DEPTH - 1) begin
            slot_in[i] = slot_ff[i + 1];
         end else begin
            slot_in[i] = slot_ff[i];
         end
      end
      if (n_push != 2'd0) begin
         slot_in[base[IDX_W-1:0]] = parse_out.first;
      end
      if (n_push == 2'd2) begin
         slot_in[base[IDX_W-1:0] + IDX_W'(1)] = parse_out.second;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < fpp_pkg::OUTQ_DEPTH; i++) begin
         slot_ff[i] <= slot_in[i];
      end
   end

endmodule

// ----- src/fen_position_parser.sv -----
// FEN position parser built from fpp_parser and fpp_outq, with types from fpp_pkg.
// Each result is registered in the result buffer and offered on rsp in arrival order.
// Throughput: one character per cycle while results drain; the rsp side takes one result
// per cycle, so a character that gives a square run and the summary yields two results.
// req_tready drops while three or more results wait in the four-entry result buffer.
// Reset (synchronous, active high) clears the parse state and empties the buffer.
`timescale 1ns / 1ps

module fen_position_parser (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [7:0]                    req_tdata,  // [7:0] char_code
   input  logic                          req_tlast,  // end_of_string
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // [2:0] rank, [5:3] start_file, [9:6] run_length, [13:10] piece,
   // [14] white_to_move, [18:15] castle_rights, [22:19] ep_column,
   // [38:23] half_move_clock, [54:39] full_move_counter, [58:55] status, rest zero
   output logic [fpp_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                          rsp_tuser,  // kind
   output logic                          rsp_tlast   // last
);

   fpp_pkg::parse_out_type parse_out;
   fpp_pkg::result_type    head;
   logic                   accept;
   logic                   space_ok;

   assign req_tready = space_ok;
   assign accept     = req_tvalid && space_ok;

   fpp_parser u_parser (
      .clock         (clock),
      .reset         (reset),
      .accept        (accept),
      .char_code     (req_tdata),
      .end_of_string (req_tlast),
      .parse_out     (parse_out)
   );

   fpp_outq u_outq (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .parse_out  (parse_out),
      .space_ok   (space_ok),
      .head_valid (rsp_tvalid),
      .head_ready (rsp_tready),
      .head       (head)
   );

   assign rsp_tdata = {5'd0, head.status, head.full_move_counter, head.half_move_clock,
                       head.ep_column, head.castle_rights, head.white_to_move, head.piece,
                       head.run_length, head.start_file, head.rank};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.last;

endmodule
